[rtl/ssa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared constants, codes, types and helpers of the size-class stack allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

   localparam int NUM_CLASSES  = 4;
   localparam int POOL_UNITS   = 4096;
   localparam int USABLE_UNITS = (POOL_UNITS < 4096) ? POOL_UNITS : 4096;
   localparam int UNIT_W       = $clog2(USABLE_UNITS);
   localparam int ADDR_W       = 13;
   localparam int CLS_W        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int ICLS_W       = $clog2(NUM_CLASSES + 1);

   localparam int NUM_REGS     = 4;
   localparam int REG_IDX_W    = 2;
   localparam int CNT_W        = 8;

   localparam int OP_W         = 2;
   localparam int STATUS_W     = 2;
   localparam int SIZE_W       = 16;
   localparam int GUARD_W      = 32;

   localparam logic [GUARD_W-1:0] GUARD_PATTERN = 32'hA5A5_A5A5;
   localparam int BASE_UNITS   = 16;
   localparam int CLASS_BYTES  = 128;
   // bytes per class step over 4-byte words gives the size shift
   localparam int CLASS_SHIFT  = $clog2(CLASS_BYTES / 4);
   localparam int QUOT_W       = SIZE_W - CLASS_SHIFT;
   localparam int CLS_NUM_W    = $clog2(QUOT_W);

   typedef enum logic [OP_W-1:0] {
      OP_INIT  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2,
      OP_CHECK = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_BAD_FREE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SRC_EXEC  = 2'd0,
      SRC_ALLOC = 2'd1,
      SRC_INIT  = 2'd2
   } out_src_type;

   typedef struct packed {
      logic        capture;
      logic        init_start;
      logic        init_step;
      logic        init_exhaust;
      logic        init_term;
      logic        alloc_read;
      logic        alloc_commit;
      logic        free_commit;
      logic        out_load;
      out_src_type out_src;
   } ssa_cmd_type;

   typedef struct packed {
      op_type op;
      logic   alloc_ok;
      logic   out_free;
      logic   cls_end;
      logic   fits;
      logic   last;
      logic   prev_nz;
      logic   exh;
   } ssa_stat_type;

   // trailing-zero count of size/32, zero when the quotient is zero
   function automatic logic [CLS_NUM_W-1:0] class_of(input logic [SIZE_W-1:0] size);
      logic [QUOT_W-1:0]    q;
      logic [CLS_NUM_W-1:0] n;
      q = size[SIZE_W-1:CLASS_SHIFT];
      n = '0;
      for (int i = QUOT_W - 1; i >= 0; i--) begin
         if (q[i]) begin
            n = CLS_NUM_W'(i);
         end
      end
      return n;
   endfunction

endpackage

[rtl/ssa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_ctrl
// Sequencer: takes one request, steps the datapath through it and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module ssa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ssa_pkg::ssa_stat_type stat,
   output ssa_pkg::ssa_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_ALLOC_RD,
      S_INIT_BLK,
      S_INIT_TERM,
      S_INIT_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd         = '0;
      cmd.out_src = ssa_pkg::SRC_EXEC;
      state_in    = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.op == ssa_pkg::OP_INIT) begin
               cmd.init_start = 1'b1;
               state_in       = S_INIT_BLK;
            end else if (stat.op == ssa_pkg::OP_ALLOC && stat.alloc_ok) begin
               cmd.alloc_read = 1'b1;
               state_in       = S_ALLOC_RD;
            end else if (stat.out_free) begin
               cmd.out_load    = 1'b1;
               cmd.out_src     = ssa_pkg::SRC_EXEC;
               cmd.free_commit = (stat.op == ssa_pkg::OP_FREE);
               state_in        = S_IDLE;
            end
         end
         S_ALLOC_RD: begin
            if (stat.out_free) begin
               cmd.alloc_commit = 1'b1;
               cmd.out_load     = 1'b1;
               cmd.out_src      = ssa_pkg::SRC_ALLOC;
               state_in         = S_IDLE;
            end
         end
         S_INIT_BLK: begin
            if (stat.cls_end) begin
               state_in = S_INIT_DONE;
            end else if (!stat.fits) begin
               // pool end: close the list built so far, if any
               cmd.init_exhaust = 1'b1;
               state_in         = stat.prev_nz ? S_INIT_TERM : S_INIT_DONE;
            end else begin
               cmd.init_step = 1'b1;
               if (stat.last) begin
                  state_in = S_INIT_TERM;
               end
            end
         end
         S_INIT_TERM: begin
            cmd.init_term = 1'b1;
            state_in      = stat.exh ? S_INIT_DONE : S_INIT_BLK;
         end
         S_INIT_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = ssa_pkg::SRC_INIT;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/ssa_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_dp
// Datapath: request registers, class heads, link memory, pool carving
// counters, class count registers and the output register.
// ----------------------------------------------------------------------------
module ssa_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ssa_pkg::ssa_cmd_type                   cmd,
   output ssa_pkg::ssa_stat_type                  stat,
   input  logic [ssa_pkg::OP_W-1:0]               req_operation,
   input  logic [ssa_pkg::SIZE_W-1:0]             req_size_words,
   input  logic [ssa_pkg::ADDR_W-1:0]             req_top_addr,
   input  logic [ssa_pkg::ADDR_W-1:0]             req_stack_addr,
   input  logic [ssa_pkg::GUARD_W-1:0]            req_guard_word,
   input  logic                                  csr_we,
   input  logic [ssa_pkg::REG_IDX_W-1:0]          csr_index,
   input  logic [ssa_pkg::CNT_W-1:0]              csr_data,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [ssa_pkg::STATUS_W-1:0]           rsp_status,
   output logic [ssa_pkg::ADDR_W-1:0]             rsp_block_top,
   output logic [ssa_pkg::ADDR_W-1:0]             rsp_guard_addr
);

   localparam int ADDR_W = ssa_pkg::ADDR_W;
   localparam int UNIT_W = ssa_pkg::UNIT_W;
   localparam int CNT_W  = ssa_pkg::CNT_W;
   localparam int CLS_W  = ssa_pkg::CLS_W;
   localparam int ICLS_W = ssa_pkg::ICLS_W;
   localparam int SIZE_W = ssa_pkg::SIZE_W;

   // request registers
   ssa_pkg::op_type               op_ff;
   logic [SIZE_W-1:0]             size_ff;
   logic [ADDR_W-1:0]             top_ff;
   logic [ADDR_W-1:0]             sp_ff;
   logic [ssa_pkg::GUARD_W-1:0]   guard_ff;

   // allocator state
   logic [ADDR_W-1:0] heads_ff [ssa_pkg::NUM_CLASSES];
   logic [ADDR_W-1:0] heads_in [ssa_pkg::NUM_CLASSES];
   logic [CNT_W-1:0]  counts_ff [ssa_pkg::NUM_REGS];
   logic [ADDR_W-1:0] link_mem_ff [ssa_pkg::USABLE_UNITS];
   logic [ADDR_W-1:0] link_rd_ff;

   // carving walk
   logic [ICLS_W-1:0] icls_ff, icls_in;
   logic [UNIT_W-1:0] pos_ff, pos_in;
   logic [UNIT_W-1:0] prev_ff, prev_in;
   logic [CNT_W-1:0]  blk_ff, blk_in;
   logic              exh_ff, exh_in;

   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ssa_pkg::STATUS_W-1:0]    out_status_ff;
   logic [ADDR_W-1:0]               out_top_ff;
   logic [ADDR_W-1:0]               out_guard_ff;

   logic [ssa_pkg::CLS_NUM_W-1:0] cls;
   logic                          cls_ok;
   logic [CLS_W-1:0]              cls_idx;
   logic [ADDR_W-1:0]             head_cur;
   logic [ADDR_W-2:0]             head_unit;
   logic                          head_unit_ok;
   logic [ADDR_W-2:0]             free_unit;
   logic                          free_ok;
   logic [ADDR_W:0]               diff;
   logic                          ovf;
   logic [ADDR_W-1:0]             gaddr;

   logic [CNT_W-1:0]  cnt_cur;
   logic              cls_end;
   logic [ADDR_W-1:0] top_u;
   logic [UNIT_W-1:0] top_unit;
   logic [ADDR_W-1:0] word;
   logic              fits;
   logic              last;
   logic              prev_nz;
   logic              out_free;

   logic              we;
   logic [UNIT_W-1:0] waddr;
   logic [ADDR_W-1:0] wdata;

   ssa_pkg::status_type res_status;
   logic [ADDR_W-1:0]   res_top;
   logic [ADDR_W-1:0]   res_guard;

   // ---------------------------------------------------------------- decode
   assign cls      = ssa_pkg::class_of(size_ff);
   assign cls_ok   = (cls < ssa_pkg::CLS_NUM_W'(ssa_pkg::NUM_CLASSES));
   assign cls_idx  = cls[CLS_W-1:0];
   assign head_cur = heads_ff[cls_idx];

   assign head_unit    = head_cur[ADDR_W-1:1];
   assign head_unit_ok = ({1'b0, head_unit} < ADDR_W'(ssa_pkg::USABLE_UNITS));

   assign free_unit = top_ff[ADDR_W-1:1];
   assign free_ok   = cls_ok && (top_ff != '0)
                      && ({1'b0, free_unit} < ADDR_W'(ssa_pkg::USABLE_UNITS));

   // a stack pointer above the top borrows and counts as overflow
   assign diff = {1'b0, top_ff} - {1'b0, sp_ff};
   assign ovf  = diff[ADDR_W] || (SIZE_W'(diff[ADDR_W-1:0]) > size_ff)
                 || (guard_ff != ssa_pkg::GUARD_PATTERN);

   assign gaddr = head_cur - size_ff[ADDR_W-1:0] + ADDR_W'(1);

   // ---------------------------------------------------------------- carving
   assign cnt_cur  = (icls_ff < ICLS_W'(ssa_pkg::NUM_REGS))
                     ? counts_ff[icls_ff[ssa_pkg::REG_IDX_W-1:0]] : '0;
   assign cls_end  = (icls_ff == ICLS_W'(ssa_pkg::NUM_CLASSES)) || (cnt_cur == '0);
   assign top_u    = ADDR_W'(pos_ff) + (ADDR_W'(ssa_pkg::BASE_UNITS) << icls_ff);
   assign fits     = (top_u < ADDR_W'(ssa_pkg::USABLE_UNITS));
   assign top_unit = top_u[UNIT_W-1:0];
   assign word     = ADDR_W'({top_unit, 1'b0});
   assign last     = (blk_ff == cnt_cur - CNT_W'(1));
   assign prev_nz  = (prev_ff != '0);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      stat          = '0;
      stat.op       = op_ff;
      stat.alloc_ok = cls_ok && (head_cur != '0);
      stat.out_free = out_free;
      stat.cls_end  = cls_end;
      stat.fits     = fits;
      stat.last     = last;
      stat.prev_nz  = prev_nz;
      stat.exh      = exh_ff;
   end

   // ---------------------------------------------------------------- requests
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= ssa_pkg::op_type'(req_operation);
         size_ff  <= req_size_words;
         top_ff   <= req_top_addr;
         sp_ff    <= req_stack_addr;
         guard_ff <= req_guard_word;
      end
   end

   // ---------------------------------------------------------------- count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ssa_pkg::NUM_REGS; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (csr_we) begin
         counts_ff[csr_index] <= csr_data;
      end
   end

   // ---------------------------------------------------------------- link memory
   always_comb begin
      we    = 1'b0;
      waddr = prev_ff;
      wdata = '0;
      if (cmd.init_step && prev_nz) begin
         we    = 1'b1;
         waddr = prev_ff;
         wdata = word;
      end else if (cmd.init_term) begin
         we    = 1'b1;
         waddr = prev_ff;
         wdata = '0;
      end else if (cmd.free_commit && free_ok) begin
         we    = 1'b1;
         waddr = free_unit[UNIT_W-1:0];
         wdata = head_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         link_mem_ff[waddr] <= wdata;
      end
      if (cmd.alloc_read) begin
         link_rd_ff <= link_mem_ff[head_unit[UNIT_W-1:0]];
      end
   end

   // ---------------------------------------------------------------- class heads
   always_comb begin
      heads_in = heads_ff;
      if (cmd.init_start) begin
         for (int i = 0; i < ssa_pkg::NUM_CLASSES; i++) begin
            heads_in[i] = '0;
         end
      end
      if (cmd.init_step && !prev_nz) begin
         heads_in[icls_ff[CLS_W-1:0]] = word;
      end
      if (cmd.alloc_commit) begin
         heads_in[cls_idx] = head_unit_ok ? link_rd_ff : '0;
      end
      if (cmd.free_commit && free_ok) begin
         heads_in[cls_idx] = top_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ssa_pkg::NUM_CLASSES; i++) begin
            heads_ff[i] <= '0;
         end
      end else begin
         heads_ff <= heads_in;
      end
   end

   // ---------------------------------------------------------------- carving walk
   always_comb begin
      icls_in = icls_ff;
      pos_in  = pos_ff;
      prev_in = prev_ff;
      blk_in  = blk_ff;
      exh_in  = exh_ff;
      if (cmd.init_start) begin
         icls_in = '0;
         pos_in  = '0;
         prev_in = '0;
         blk_in  = '0;
         exh_in  = 1'b0;
      end
      if (cmd.init_step) begin
         pos_in  = top_unit;
         prev_in = top_unit;
         blk_in  = blk_ff + CNT_W'(1);
      end
      if (cmd.init_exhaust) begin
         exh_in = 1'b1;
      end
      if (cmd.init_term && !exh_ff) begin
         icls_in = icls_ff + ICLS_W'(1);
         prev_in = '0;
         blk_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         icls_ff <= '0;
         pos_ff  <= '0;
         prev_ff <= '0;
         blk_ff  <= '0;
         exh_ff  <= 1'b0;
      end else begin
         icls_ff <= icls_in;
         pos_ff  <= pos_in;
         prev_ff <= prev_in;
         blk_ff  <= blk_in;
         exh_ff  <= exh_in;
      end
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      res_status = ssa_pkg::ST_OK;
      res_top    = '0;
      res_guard  = '0;
      case (cmd.out_src)
         ssa_pkg::SRC_EXEC: begin
            case (op_ff)
               ssa_pkg::OP_ALLOC: res_status = ssa_pkg::ST_EXHAUSTED;
               ssa_pkg::OP_FREE:  res_status = free_ok ? ssa_pkg::ST_OK
                                                       : ssa_pkg::ST_BAD_FREE;
               ssa_pkg::OP_CHECK: res_status = ovf ? ssa_pkg::ST_OVERFLOW
                                                   : ssa_pkg::ST_OK;
               default:           res_status = ssa_pkg::ST_OK;
            endcase
         end
         ssa_pkg::SRC_ALLOC: begin
            res_status = ssa_pkg::ST_OK;
            res_top    = head_cur;
            res_guard  = gaddr;
         end
         ssa_pkg::SRC_INIT: begin
            res_status = exh_ff ? ssa_pkg::ST_EXHAUSTED : ssa_pkg::ST_OK;
         end
         default: begin
            res_status = ssa_pkg::ST_OK;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status_ff <= res_status;
         out_top_ff    <= res_top;
         out_guard_ff  <= res_guard;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_block_top  = out_top_ff;
   assign rsp_guard_addr = out_guard_ff;

endmodule

[rtl/size_class_stack_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_stack_allocator
// Stack allocator with power-of-two size classes kept as LIFO free lists.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  operation, size, top, sp, guard
//  rsp      out        rsp_valid/rsp_stall  status, block_top, guard_addr
//  csr      in         csr_valid/csr_ready  csr_index, csr_data (class counts)
//
//  Check, free and a failed alloc pass through capture and execute; a good
//  alloc adds a read step, as the link memory read is registered before
//  the head moves. Init carves block by block and closes each list it built.
//  Reset clears the heads and counts; no memory clearing pass.
//  The result sits in an output register: a new request is taken while it
//  waits, and the sequencer holds its last step until that register frees.
// ----------------------------------------------------------------------------
module size_class_stack_allocator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ssa_pkg::OP_W-1:0]            req_operation,
   input  logic [ssa_pkg::SIZE_W-1:0]          req_size_words,
   input  logic [ssa_pkg::ADDR_W-1:0]          req_top_addr,
   input  logic [ssa_pkg::ADDR_W-1:0]          req_stack_addr,
   input  logic [ssa_pkg::GUARD_W-1:0]         req_guard_word,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ssa_pkg::STATUS_W-1:0]        rsp_status,
   output logic [ssa_pkg::ADDR_W-1:0]          rsp_block_top,
   output logic [ssa_pkg::ADDR_W-1:0]          rsp_guard_addr,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ssa_pkg::REG_IDX_W-1:0]       csr_index,
   input  logic [ssa_pkg::CNT_W-1:0]           csr_data
);

   ssa_pkg::ssa_cmd_type  cmd;
   ssa_pkg::ssa_stat_type stat;

   // count registers take a write in any cycle
   assign csr_ready = 1'b1;

   ssa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ssa_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_operation  (req_operation),
      .req_size_words (req_size_words),
      .req_top_addr   (req_top_addr),
      .req_stack_addr (req_stack_addr),
      .req_guard_word (req_guard_word),
      .csr_we         (csr_valid & csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_block_top  (rsp_block_top),
      .rsp_guard_addr (rsp_guard_addr)
   );

endmodule

[rtl/ssa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ssa_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [ssa_pkg::STATUS_W-1:0]        rsp_status,
   input logic [ssa_pkg::ADDR_W-1:0]          rsp_block_top,
   input logic [ssa_pkg::ADDR_W-1:0]          rsp_guard_addr
);

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_valid && rsp_stall |=> reset
         || (rsp_valid && $stable(rsp_status) && $stable(rsp_block_top)
             && $stable(rsp_guard_addr)))
      else $error("stalled result changed");

   // one request at a time: a transfer closes the request side next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !reset && req_valid && !req_stall |=> reset || req_stall)
      else $error("request taken while another is in progress");

   // only a good alloc reports addresses
   a_addr_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ssa_pkg::ST_OK)
         |-> (rsp_block_top == '0) && (rsp_guard_addr == '0))
      else $error("addresses reported with a failing status");

   // a result never appears in the cycle right after a request transfer
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      !reset && req_valid && !req_stall && !rsp_valid |=> reset || !rsp_valid)
      else $error("result faster than the datapath allows");

endmodule

bind size_class_stack_allocator ssa_checker u_ssa_checker (.*);
